### design/cdte_pkg.sv
// Package for the civil date to epoch seconds converter.
// Holds calendar constants, field widths and the cumulative month table.
// No dependencies.
`default_nettype none

package cdte_pkg;

  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int SECOND_W   = 6;
  localparam int EPOCH_W    = 32;
  localparam int IN_DATA_W  = 40;
  localparam int DAYS_W     = 20;
  localparam int TSEC_W     = 17;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 12'd1970;
  // Leap years in 1..1969 under the Gregorian rule.
  localparam logic [10:0]       LEAPS_BEFORE_EPOCH = 11'd477;
  localparam logic [8:0]        DAYS_PER_YEAR      = 9'd365;
  localparam logic [16:0]       SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0]       SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]        SECS_PER_MIN       = 6'd60;
  // x / 25 == (x * 41) >> 10 for every x below 1024.
  localparam logic [5:0]        RECIP_25           = 6'd41;
  localparam int                RECIP_SHIFT        = 10;
  localparam logic [4:0]        DIV_25             = 5'd25;

  // Days of a common year that come before the first of the given month.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### design/civil_date_to_epoch_seconds.sv
// Throughput: one request per cycle unless m_tready stalls the output; each of
// the five stages holds one request and moves on whenever the stage after it is
// empty or moving.
// Reset: rst (synchronous, active high) clears all stage valid bits; data
// registers are not reset.
// Depends on cdte_pkg.
`default_nettype none

module civil_date_to_epoch_seconds
  import cdte_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // s_tdata: year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero pad [39:38]
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  // s_tuser: date_valid[0], time_valid[1]
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // m_tdata: epoch_seconds[31:0]
  output logic [EPOCH_W-1:0]        m_tdata
);

  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;
  logic [YEAR_W-1:0]   year_m1;

  assign year   = s_tdata[11:0];
  assign month  = s_tdata[15:12];
  assign day    = s_tdata[20:16];
  assign hour   = s_tdata[25:21];
  assign minute = s_tdata[31:26];
  assign second = s_tdata[37:32];
  assign year_m1 = year - 12'd1;

  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;

  assign en5 = !v5 || m_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  // Stage 1: range checks, reciprocal products for the divisions by 25,
  // month table lookup and the time of day in seconds.
  logic                ok1;
  logic [YEAR_W-1:0]   ydiff1;
  logic [9:0]          y4_1;
  logic [15:0]         p100_1;
  logic [13:0]         p400_1;
  logic [9:0]          yr4_1;
  logic [15:0]         pl100_1;
  logic [13:0]         pl400_1;
  logic                mod4z1, mod16z1;
  logic [8:0]          cum1;
  logic                mgt2_1;
  logic [DAY_W-1:0]    dm1_1;
  logic [TSEC_W-1:0]   tsec1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
    if (en1) begin
      ok1     <= s_tuser[0] && s_tuser[1] && (year >= EPOCH_YEAR) &&
                 (month >= 4'd1) && (month <= 4'd12) && (day != '0);
      ydiff1  <= year - EPOCH_YEAR;
      y4_1    <= year_m1[11:2];
      p100_1  <= 16'(year_m1[11:2]) * 16'(RECIP_25);
      p400_1  <= 14'(year_m1[11:4]) * 14'(RECIP_25);
      yr4_1   <= year[11:2];
      pl100_1 <= 16'(year[11:2]) * 16'(RECIP_25);
      pl400_1 <= 14'(year[11:4]) * 14'(RECIP_25);
      mod4z1  <= (year[1:0] == 2'd0);
      mod16z1 <= (year[3:0] == 4'd0);
      cum1    <= days_before_month(month);
      mgt2_1  <= (month > 4'd2);
      dm1_1   <= day - 5'd1;
      tsec1   <= 17'(hour) * 17'(SECS_PER_HOUR) + 17'(minute) * 17'(SECS_PER_MIN) +
                 17'(second);
    end
  end

  // Stage 2: days of the whole years, leap-year count since the epoch and the leap flag of this year.
  logic [5:0]  q100, ql100;
  logic [3:0]  q400, ql400;
  logic [9:0]  rem100;
  logic [7:0]  rem400;
  logic [10:0] leaps_sum;

  assign q100   = p100_1[15:RECIP_SHIFT];
  assign q400   = p400_1[13:RECIP_SHIFT];
  assign ql100  = pl100_1[15:RECIP_SHIFT];
  assign ql400  = pl400_1[13:RECIP_SHIFT];
  assign rem100 = yr4_1 - 10'(ql100 * 10'(DIV_25));
  assign rem400 = yr4_1[9:2] - 8'(ql400 * 8'(DIV_25));
  assign leaps_sum = 11'(y4_1) - 11'(q100) + 11'(q400) - LEAPS_BEFORE_EPOCH;

  logic                ok2;
  logic [DAYS_W-1:0]   ydays2;
  logic [9:0]          leaps2;
  logic                leap2;
  logic [8:0]          cum2;
  logic                mgt2_2;
  logic [DAY_W-1:0]    dm1_2;
  logic [TSEC_W-1:0]   tsec2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      ok2    <= ok1;
      ydays2 <= 20'(ydiff1) * 20'(DAYS_PER_YEAR);
      leaps2 <= leaps_sum[9:0];
      // Divisible by 4, and either not by 100 or also by 400.
      leap2  <= mod4z1 && ((rem100 != '0) || (mod16z1 && (rem400 == '0)));
      cum2   <= cum1;
      mgt2_2 <= mgt2_1;
      dm1_2  <= dm1_1;
      tsec2  <= tsec1;
    end
  end

  // Stage 3: day count since the epoch.
  logic                ok3;
  logic [DAYS_W-1:0]   days3;
  logic [TSEC_W-1:0]   tsec3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      ok3   <= ok2;
      days3 <= ydays2 + 20'(leaps2) + 20'(cum2) + 20'(leap2 && mgt2_2) + 20'(dm1_2);
      tsec3 <= tsec2;
    end
  end

  // Stage 4: days to seconds, wrapping modulo 2^32.
  logic [36:0]         prod_full;
  logic                ok4;
  logic [EPOCH_W-1:0]  prod4;
  logic [TSEC_W-1:0]   tsec4;

  assign prod_full = 37'(days3) * 37'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      ok4   <= ok3;
      prod4 <= prod_full[EPOCH_W-1:0];
      tsec4 <= tsec3;
    end
  end

  // Stage 5: output register; a rejected request gives zero.
  logic [EPOCH_W-1:0] out5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
    if (en5) begin
      out5 <= ok4 ? (prod4 + 32'(tsec4)) : '0;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = out5;

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2 || !v3 || !v4 || !v5) |-> s_tready)
    else $error("input stalled while the pipeline has an empty stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en4) |=> ($stable(prod4) && v4))
    else $error("stage 4 product changed while stalled");

  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    (m_tready && v4) |=> v5)
    else $error("request lost between stage 4 and the output");

endmodule

`default_nettype wire

### dv/civil_date_to_epoch_seconds_tb.sv
// Self-checking testbench for civil_date_to_epoch_seconds: directed calendar corners, then
// random timestamps with random gaps on both stream sides, checked against a local predictor.
// Depends on cdte_pkg and the civil_date_to_epoch_seconds RTL.
`default_nettype none

module civil_date_to_epoch_seconds_tb;
  import cdte_pkg::*;

  typedef struct packed {
    logic                date_valid;
    logic                time_valid;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                drain;  // hold this request until every result is back
  } civil_stamp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // s_tdata: year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero pad [39:38]
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // s_tuser: date_valid[0], time_valid[1]
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // m_tdata: epoch_seconds[31:0]
  logic [EPOCH_W-1:0]   m_tdata;

  civil_stamp_t         pending_stamps[$];
  logic [EPOCH_W-1:0]   expected_secs[$];
  civil_stamp_t         on_bus = '0;
  int unsigned          issued_cnt = 0;
  int unsigned          taken_cnt = 0;
  int unsigned          total_stamps = 0;
  int unsigned          send_gap = 0;
  int unsigned          stall_left = 0;
  bit                   send_quiet = 1'b0;
  bit                   recv_quiet = 1'b0;
  int unsigned          bad_results = 0;
  int unsigned          checked_cnt = 0;
  int unsigned          zero_cnt = 0;
  int unsigned          drain_cnt = 0;

  civil_date_to_epoch_seconds u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] leaps_upto(input logic [31:0] n);
    return n / 32'd4 - n / 32'd100 + n / 32'd400;
  endfunction

  function automatic logic [31:0] month_length(input int m, input bit leap);
    case (m)
      2:           return leap ? 32'd29 : 32'd28;
      4, 6, 9, 11: return 32'd30;
      default:     return 32'd31;
    endcase
  endfunction

  // Seconds since 1970-01-01, wrapping at 32 bits; zero for any rejected stamp.
  function automatic logic [31:0] unix_seconds(input civil_stamp_t s);
    logic [31:0] y;
    logic [31:0] days;
    bit          leap;
    if (!s.date_valid || !s.time_valid || s.year < EPOCH_YEAR || s.month == 0 ||
        s.month > 12 || s.day == 0)
      return 32'd0;
    y    = 32'(s.year);
    leap = ((y % 32'd4 == 0) && (y % 32'd100 != 0)) || (y % 32'd400 == 0);
    days = 32'd365 * (y - 32'(EPOCH_YEAR)) + leaps_upto(y - 32'd1) -
           leaps_upto(32'(EPOCH_YEAR) - 32'd1);
    for (int m = 1; m < int'(s.month); m++)
      days += month_length(m, leap);
    days += 32'(s.day) - 32'd1;
    return days * 32'd86400 + 32'(s.hour) * 32'd3600 + 32'(s.minute) * 32'd60 +
           32'(s.second);
  endfunction

  // Mostly no idling, some short gaps and an occasional long one.
  function automatic int unsigned idle_cycles(input bit quiet);
    int unsigned r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_stamp(input bit dv, input bit tv, input int y, input int mo,
                           input int d, input int h, input int mi, input int se,
                           input bit drain);
    civil_stamp_t s;
    s.date_valid = dv;
    s.time_valid = tv;
    s.year       = YEAR_W'(y);
    s.month      = MONTH_W'(mo);
    s.day        = DAY_W'(d);
    s.hour       = HOUR_W'(h);
    s.minute     = MINUTE_W'(mi);
    s.second     = SECOND_W'(se);
    s.drain      = drain;
    pending_stamps.push_back(s);
    total_stamps++;
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && taken_cnt != issued_cnt) begin
      // Current request not yet taken; hold it.
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      s_tvalid <= 1'b0;
    end else if (pending_stamps.size() != 0 &&
                 !(pending_stamps[0].drain && expected_secs.size() != 0)) begin
      on_bus = pending_stamps.pop_front();
      if (on_bus.drain)
        drain_cnt++;
      s_tdata    <= {2'b00, on_bus.second, on_bus.minute, on_bus.hour, on_bus.day,
                     on_bus.month, on_bus.year};
      s_tuser    <= {on_bus.time_valid, on_bus.date_valid};
      s_tvalid   <= 1'b1;
      issued_cnt <= issued_cnt + 1;
      if ($urandom_range(0, 39) == 0)
        send_quiet = !send_quiet;
      send_gap   <= idle_cycles(send_quiet);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 39) == 0)
        recv_quiet = !recv_quiet;
      stall_left <= idle_cycles(recv_quiet);
    end
  end

  // Result checking first, then prediction for a request taken at this edge.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_secs.size() == 0) begin
          if (bad_results < 10)
            $display("%0t: result %0d arrived with nothing expected", $realtime, m_tdata);
          bad_results++;
        end else begin
          want = expected_secs.pop_front();
          checked_cnt++;
          if (m_tdata !== want) begin
            if (bad_results < 10)
              $display("%0t: epoch_seconds expected %0d, got %0d", $realtime, want, m_tdata);
            bad_results++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = unix_seconds(on_bus);
        if (want == 0)
          zero_cnt++;
        expected_secs.push_back(want);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    civil_stamp_t s;
    int unsigned  r;
    int unsigned  q;

    // Directed corners.
    add_stamp(0, 1, 2024, 6, 15, 12, 30, 45, 0);
    add_stamp(1, 0, 2024, 6, 15, 12, 30, 45, 0);
    add_stamp(1, 1, 1969, 12, 31, 23, 59, 59, 0);
    add_stamp(1, 1, 1970, 1, 1, 0, 0, 0, 0);
    add_stamp(1, 1, 2024, 0, 10, 1, 2, 3, 0);
    add_stamp(1, 1, 2024, 13, 10, 1, 2, 3, 0);
    add_stamp(1, 1, 2024, 15, 10, 1, 2, 3, 0);
    add_stamp(1, 1, 2024, 5, 0, 1, 2, 3, 0);
    // A day past the end of February runs on into March.
    add_stamp(1, 1, 2000, 2, 30, 8, 0, 0, 0);
    add_stamp(1, 1, 2024, 2, 29, 31, 63, 63, 0);
    // Latest possible stamp wraps past 32 bits.
    add_stamp(1, 1, 4095, 12, 31, 31, 63, 63, 0);
    add_stamp(1, 1, 2100, 3, 1, 0, 0, 1, 0);
    add_stamp(1, 1, 2000, 3, 1, 0, 0, 1, 0);
    for (int m = 1; m <= 12; m++)
      add_stamp(1, 1, 2023, m, 31, 23, 59, 59, 0);

    // Random part: mostly well-formed stamps, some spoiled ones, some raw noise.
    for (int i = 0; i < 450; i++) begin
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 99);
      s.date_valid = 1'b1;
      s.time_valid = 1'b1;
      s.year   = (q < 70) ? YEAR_W'($urandom_range(1970, 2106)) :
                 (q < 95) ? YEAR_W'($urandom_range(1970, 4095)) :
                            YEAR_W'($urandom_range(3900, 4095));
      s.month  = MONTH_W'($urandom_range(1, 12));
      s.day    = DAY_W'($urandom_range(1, 31));
      s.hour   = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom) : HOUR_W'($urandom_range(0, 23));
      s.minute = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom) :
                                                MINUTE_W'($urandom_range(0, 59));
      s.second = ($urandom_range(0, 9) == 0) ? SECOND_W'($urandom) :
                                                SECOND_W'($urandom_range(0, 59));
      if (r < 12) begin
        s.date_valid = 1'($urandom);
        s.time_valid = 1'($urandom);
        s.year       = YEAR_W'($urandom);
        s.month      = MONTH_W'($urandom);
        s.day        = DAY_W'($urandom);
        s.hour       = HOUR_W'($urandom);
        s.minute     = MINUTE_W'($urandom);
        s.second     = SECOND_W'($urandom);
      end else if (r < 22) begin
        case ($urandom_range(0, 4))
          0:       s.date_valid = 1'b0;
          1:       s.time_valid = 1'b0;
          2:       s.year = YEAR_W'($urandom_range(0, 1969));
          3:       s.month = ($urandom_range(0, 1) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
          default: s.day = '0;
        endcase
      end
      s.drain = (i == 0 || i == 225);
      pending_stamps.push_back(s);
      total_stamps++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt != total_stamps)
      @(posedge clk);
    while (expected_secs.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Converted %0d requests (%0d expected zero), %0d drain pauses, %0d mismatches.",
             checked_cnt, zero_cnt, drain_cnt, bad_results);
    if (bad_results == 0 && expected_secs.size() == 0)
      $display("civil_date_to_epoch_seconds_tb: clean");
    else
      $display("civil_date_to_epoch_seconds_tb: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("Run timed out with %0d of %0d requests taken.", taken_cnt, total_stamps);
    $display("civil_date_to_epoch_seconds_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/cdte_pkg.sv
design/civil_date_to_epoch_seconds.sv
dv/civil_date_to_epoch_seconds_tb.sv
